>>> rtl/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_BURST  = 3'b010,
        PH_LISTEN = 3'b100
    } t_phase;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HALF_PERIOD = 2'd0;
    localparam t_cfg_idx CFG_BURST_LEN   = 2'd1;
    localparam t_cfg_idx CFG_OFFSET      = 2'd2;

    localparam int CFG_DATA_BITS = 8;
    localparam int DIST_BITS     = 10;

    localparam logic [7:0] RST_HALF_PERIOD = 8'd12;
    localparam logic [3:0] RST_BURST_LEN   = 4'd8;
    localparam logic [3:0] RST_OFFSET      = 4'd3;

    localparam logic [DIST_BITS-1:0] OVER_CODE  = 10'd999;
    localparam logic [DIST_BITS:0]   DIST_LIMIT = 11'd998;

    // running remainder of (count/10)*17 modulo 100
    localparam logic [7:0] REM_STEP   = 8'd17;
    localparam logic [7:0] REM_BASE   = 8'd100;
    localparam logic [3:0] DIGIT_LAST = 4'd9;
    localparam logic [4:0] DEC_TEN    = 5'd10;
    localparam logic [4:0] DEC_TWENTY = 5'd20;

    typedef struct packed {
        logic [7:0] half_period;
        logic [3:0] burst_len;
        logic [3:0] offset;
    } t_cfg;

    typedef struct packed {
        logic                 tx_level;
        logic                 done_res;
        logic [DIST_BITS-1:0] distance_value;
        logic                 over_range;
        logic [3:0]           digit_hundreds;
        logic [3:0]           digit_tens;
        logic [3:0]           digit_units;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/uer_core.sv
`timescale 1ns / 1ps
`default_nettype none

module uer_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_step,
    input  wire               i_start,
    input  wire               i_echo,
    input  uer_pkg::t_cfg     i_cfg,
    output uer_pkg::t_result  o_res
);

    uer_pkg::t_phase r_phase, n_phase;
    logic [3:0]            r_pulse_cnt, n_pulse_cnt;
    logic [7:0]            r_half_cnt, n_half_cnt;
    logic [COUNT_BITS-1:0] r_echo_cnt, n_echo_cnt;
    logic                  r_tx, n_tx;
    // distance base tracked as the echo count grows: mod-10 tick count,
    // remainder modulo 100, binary value, decimal digits, saturation flag
    logic [3:0]            r_mod10, n_mod10;
    logic [6:0]            r_rem, n_rem;
    logic [uer_pkg::DIST_BITS-1:0] r_base, n_base;
    logic [3:0]            r_base_h, n_base_h;
    logic [3:0]            r_base_t, n_base_t;
    logic [3:0]            r_base_u, n_base_u;
    logic                  r_big, n_big;
    logic [uer_pkg::DIST_BITS-1:0] r_dist, n_dist;
    logic                  r_over, n_over;
    logic [3:0]            r_dig_h, n_dig_h;
    logic [3:0]            r_dig_t, n_dig_t;
    logic [3:0]            r_dig_u, n_dig_u;
    logic                  n_done;

    logic [uer_pkg::DIST_BITS:0] fin_sum;
    logic                        fin_over;
    logic [4:0]                  u_sum;
    logic [3:0]                  fin_u;
    logic [1:0]                  u_carry;
    logic [4:0]                  t_sum;
    logic [3:0]                  fin_t;
    logic                        t_carry;
    logic [3:0]                  fin_h;
    logic [7:0]                  rem_sum;
    logic [4:0]                  pulse_next;

    // finished distance from the current base plus offset, in binary and decimal
    always_comb begin
        fin_sum  = {1'b0, r_base} + {{(uer_pkg::DIST_BITS-3){1'b0}}, i_cfg.offset};
        fin_over = r_big || (fin_sum > uer_pkg::DIST_LIMIT);
        u_sum    = {1'b0, r_base_u} + {1'b0, i_cfg.offset};
        if (u_sum >= uer_pkg::DEC_TWENTY) begin
            fin_u   = 4'(u_sum - uer_pkg::DEC_TWENTY);
            u_carry = 2'd2;
        end else if (u_sum >= uer_pkg::DEC_TEN) begin
            fin_u   = 4'(u_sum - uer_pkg::DEC_TEN);
            u_carry = 2'd1;
        end else begin
            fin_u   = u_sum[3:0];
            u_carry = 2'd0;
        end
        t_sum = {1'b0, r_base_t} + {3'd0, u_carry};
        if (t_sum >= uer_pkg::DEC_TEN) begin
            fin_t   = 4'(t_sum - uer_pkg::DEC_TEN);
            t_carry = 1'b1;
        end else begin
            fin_t   = t_sum[3:0];
            t_carry = 1'b0;
        end
        fin_h = r_base_h + {3'd0, t_carry};
    end

    always_comb begin
        n_phase     = r_phase;
        n_pulse_cnt = r_pulse_cnt;
        n_half_cnt  = r_half_cnt;
        n_echo_cnt  = r_echo_cnt;
        n_tx        = r_tx;
        n_mod10     = r_mod10;
        n_rem       = r_rem;
        n_base      = r_base;
        n_base_h    = r_base_h;
        n_base_t    = r_base_t;
        n_base_u    = r_base_u;
        n_big       = r_big;
        n_dist      = r_dist;
        n_over      = r_over;
        n_dig_h     = r_dig_h;
        n_dig_t     = r_dig_t;
        n_dig_u     = r_dig_u;
        n_done      = 1'b0;
        rem_sum     = {1'b0, r_rem} + uer_pkg::REM_STEP;
        pulse_next  = {1'b0, r_pulse_cnt} + 5'd1;

        case (r_phase)
            uer_pkg::PH_IDLE: begin
                if (i_start) begin
                    n_phase     = uer_pkg::PH_BURST;
                    n_tx        = 1'b1;
                    n_half_cnt  = 8'd1;
                    n_pulse_cnt = 4'd0;
                end
            end
            uer_pkg::PH_BURST: begin
                if (r_half_cnt >= i_cfg.half_period) begin
                    n_half_cnt = 8'd1;
                    if (r_tx) begin
                        n_tx = 1'b0;
                    end else if (pulse_next >= {1'b0, i_cfg.burst_len}) begin
                        n_phase     = uer_pkg::PH_LISTEN;
                        n_pulse_cnt = 4'd0;
                        n_half_cnt  = 8'd0;
                        n_echo_cnt  = '0;
                        n_mod10     = 4'd0;
                        n_rem       = 7'd0;
                        n_base      = '0;
                        n_base_h    = 4'd0;
                        n_base_t    = 4'd0;
                        n_base_u    = 4'd0;
                        n_big       = 1'b0;
                    end else begin
                        n_pulse_cnt = pulse_next[3:0];
                        n_tx        = 1'b1;
                    end
                end else begin
                    n_half_cnt = r_half_cnt + 8'd1;
                end
            end
            uer_pkg::PH_LISTEN: begin
                if (!i_echo) begin
                    n_phase = uer_pkg::PH_IDLE;
                    n_done  = 1'b1;
                    n_over  = fin_over;
                    if (fin_over) begin
                        n_dist  = uer_pkg::OVER_CODE;
                        n_dig_h = uer_pkg::DIGIT_LAST;
                        n_dig_t = uer_pkg::DIGIT_LAST;
                        n_dig_u = uer_pkg::DIGIT_LAST;
                    end else begin
                        n_dist  = fin_sum[uer_pkg::DIST_BITS-1:0];
                        n_dig_h = fin_h;
                        n_dig_t = fin_t;
                        n_dig_u = fin_u;
                    end
                end else if (&r_echo_cnt) begin
                    // counter wraps before the echo line falls
                    n_echo_cnt = '0;
                    n_phase    = uer_pkg::PH_IDLE;
                    n_done     = 1'b1;
                    n_over     = 1'b1;
                    n_dist     = uer_pkg::OVER_CODE;
                    n_dig_h    = uer_pkg::DIGIT_LAST;
                    n_dig_t    = uer_pkg::DIGIT_LAST;
                    n_dig_u    = uer_pkg::DIGIT_LAST;
                end else begin
                    n_echo_cnt = r_echo_cnt + 1'b1;
                    if (r_mod10 == uer_pkg::DIGIT_LAST) begin
                        n_mod10 = 4'd0;
                        if (rem_sum >= uer_pkg::REM_BASE) begin
                            n_rem = 7'(rem_sum - uer_pkg::REM_BASE);
                            // advance the base by one, saturate past 999
                            if (!r_big) begin
                                if (r_base == uer_pkg::OVER_CODE) begin
                                    n_big = 1'b1;
                                end else begin
                                    n_base = r_base + 1'b1;
                                    if (r_base_u == uer_pkg::DIGIT_LAST) begin
                                        n_base_u = 4'd0;
                                        if (r_base_t == uer_pkg::DIGIT_LAST) begin
                                            n_base_t = 4'd0;
                                            n_base_h = r_base_h + 4'd1;
                                        end else begin
                                            n_base_t = r_base_t + 4'd1;
                                        end
                                    end else begin
                                        n_base_u = r_base_u + 4'd1;
                                    end
                                end
                            end
                        end else begin
                            n_rem = rem_sum[6:0];
                        end
                    end else begin
                        n_mod10 = r_mod10 + 4'd1;
                    end
                end
            end
            default: begin
                n_phase = uer_pkg::PH_IDLE;
                n_tx    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= uer_pkg::PH_IDLE;
            r_pulse_cnt <= 4'd0;
            r_half_cnt  <= 8'd0;
            r_echo_cnt  <= '0;
            r_tx        <= 1'b0;
            r_mod10     <= 4'd0;
            r_rem       <= 7'd0;
            r_base      <= '0;
            r_base_h    <= 4'd0;
            r_base_t    <= 4'd0;
            r_base_u    <= 4'd0;
            r_big       <= 1'b0;
            r_dist      <= '0;
            r_over      <= 1'b0;
            r_dig_h     <= 4'd0;
            r_dig_t     <= 4'd0;
            r_dig_u     <= 4'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pulse_cnt <= n_pulse_cnt;
            r_half_cnt  <= n_half_cnt;
            r_echo_cnt  <= n_echo_cnt;
            r_tx        <= n_tx;
            r_mod10     <= n_mod10;
            r_rem       <= n_rem;
            r_base      <= n_base;
            r_base_h    <= n_base_h;
            r_base_t    <= n_base_t;
            r_base_u    <= n_base_u;
            r_big       <= n_big;
            r_dist      <= n_dist;
            r_over      <= n_over;
            r_dig_h     <= n_dig_h;
            r_dig_t     <= n_dig_t;
            r_dig_u     <= n_dig_u;
        end
    end

    always_comb begin
        o_res.tx_level       = n_tx;
        o_res.done_res       = n_done;
        o_res.distance_value = n_dist;
        o_res.over_range     = n_over;
        o_res.digit_hundreds = n_dig_h;
        o_res.digit_tens     = n_dig_t;
        o_res.digit_units    = n_dig_u;
    end

endmodule

`default_nettype wire

>>> rtl/ultrasonic_echo_ranger_unit.sv
// An accepted input word gives its result word in the cycle after.
// Throughput: one word per cycle while the output is not stalled; the tick
// update and distance finish are short logic between state and output registers.
// Reset (synchronous, active low): idle, counters and held distance zero,
// configuration back to half period 12, burst 8, offset 3, no output word.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_unit #(
    parameter int COUNT_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [7:0]  i_cfg_data,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // [0] start_req, [1] echo_line, [7:2] zero
    input  wire [7:0]  s_axis_tdata,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // [0] tx_level, [1] done_res, [11:2] distance_value, [12] over_range,
    // [16:13] digit_hundreds, [20:17] digit_tens, [24:21] digit_units, [31:25] zero
    output logic [31:0] m_axis_tdata
);

    uer_pkg::t_cfg    r_cfg;
    uer_pkg::t_result core_res;
    uer_pkg::t_result r_out;
    logic             r_out_valid;
    logic             step;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period <= uer_pkg::RST_HALF_PERIOD;
            r_cfg.burst_len   <= uer_pkg::RST_BURST_LEN;
            r_cfg.offset      <= uer_pkg::RST_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                uer_pkg::CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data;
                uer_pkg::CFG_BURST_LEN:   r_cfg.burst_len   <= i_cfg_data[3:0];
                uer_pkg::CFG_OFFSET:      r_cfg.offset      <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    uer_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_start (s_axis_tdata[0]),
        .i_echo  (s_axis_tdata[1]),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the word until taken
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.digit_units, r_out.digit_tens,
                            r_out.digit_hundreds, r_out.over_range,
                            r_out.distance_value, r_out.done_res, r_out.tx_level};

endmodule

`default_nettype wire

>>> rtl/uer_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module uer_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);

    logic [10:0] composed;

    assign composed = 11'(m_axis_tdata[16:13]) * 11'd100
                    + 11'(m_axis_tdata[20:17]) * 11'd10
                    + 11'(m_axis_tdata[24:21]);

    // over-range flag agrees with the held distance code
    a_over_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12] == (m_axis_tdata[11:2] == 10'd999)))
        else $error("over_range disagrees with distance_value");

    // decimal digits rebuild the held distance
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (composed == {1'b0, m_axis_tdata[11:2]}))
        else $error("digits do not match distance_value");

    // a measurement ends in the listen phase, transmitter quiet
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> !m_axis_tdata[0])
        else $error("done word with transmitter high");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");

    // every accepted input word shows up as an output word on the next cycle
    a_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted word did not produce an output word");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
